// ----- rtl/askc_pkg.sv -----
package askc_pkg;

   localparam int NUM_KEYWORDS    = 45;
   localparam int MAX_KEYWORD_LEN = 14;
   localparam int CHAR_W          = 8;
   localparam int FLAGS_W         = 2;
   localparam int POS_W           = $clog2(MAX_KEYWORD_LEN + 2);
   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

   localparam int FLAG_CHECKED = 0;
   localparam int FLAG_MOBILE  = 1;

   // distance from upper to lower case in ascii
   localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

   typedef logic [NUM_KEYWORDS-1:0]      kw_mask_type;
   typedef logic [POS_W-1:0]             pos_type;
   typedef logic [CHAR_W-1:0]            char_type;
   typedef logic [FLAGS_W-1:0]           flags_type;
   typedef logic [MAX_KEYWORD_LEN*8-1:0] kw_text_type;

   localparam pos_type     POS_MAX   = pos_type'(MAX_KEYWORD_LEN + 1);
   localparam kw_mask_type ALL_ALIVE = '1;

   typedef struct packed {
      logic     letter;
      logic     separator;
      logic     is_last;
      char_type code;
   } entry_type;

   // keyword text, first letter in the top byte, zero padded
   function automatic kw_text_type kw_text(input int k);
      kw_text_type text;
      case (k)
         0:  text = {56'h616e64726f6964, 56'h0};
         1:  text = {32'h6d696470, 80'h0};
         2:  text = {48'h7461626c6574, 64'h0};
         3:  text = {32'h69706164, 80'h0};
         4:  text = {48'h6970686f6e65, 64'h0};
         5:  text = {32'h69706f64, 80'h0};
         6:  text = {48'h6974756e6573, 64'h0};
         7:  text = {56'h73616d73756e67, 56'h0};
         8:  text = {24'h736965, 88'h0};
         9:  text = {32'h6d6f6269, 80'h0};
         10: text = {64'h706c6179626f6f6b, 48'h0};
         11: text = {80'h626c61636b6265727279, 32'h0};
         12: text = {48'h6d6f62696c65, 64'h0};
         13: text = {56'h637269636b6574, 56'h0};
         14: text = {32'h64656c6c, 80'h0};
         15: text = {64'h69656d6f62696c65, 48'h0};
         16: text = {40'h70686f6e65, 72'h0};
         17: text = {48'h6b696e646c65, 64'h0};
         18: text = {16'h6c67, 96'h0};
         19: text = {24'h6c6765, 88'h0};
         20: text = {24'h6d6f74, 88'h0};
         21: text = {80'h736d61727470686f6e65, 32'h0};
         22: text = {64'h6e696e74656e646f, 48'h0};
         23: text = {40'h6e6f6b6961, 72'h0};
         24: text = {32'h6d696e69, 80'h0};
         25: text = {72'h73796d6269616e6f73, 40'h0};
         26: text = {56'h73796d6269616e, 56'h0};
         27: text = {48'h73796d626f73, 64'h0};
         28: text = {48'h6e6f6b69616e, 64'h0};
         29: text = {48'h6e6f6b696178, 64'h0};
         30: text = {48'h6e6f6b696163, 64'h0};
         31: text = {24'h737076, 88'h0};
         32: text = {32'h70616c6d, 80'h0};
         33: text = {80'h70616c6d736f75726365, 32'h0};
         34: text = {48'h70616c6d6f73, 64'h0};
         35: text = 112'h6d6f62696c656578706c6f726572;
         36: text = 112'h726571776972656c657373776562;
         37: text = {96'h736f6e796572696373736f6e, 16'h0};
         38: text = {104'h736f6e796572696373736f6e6b, 8'h0};
         39: text = {24'h707370, 88'h0};
         40: text = {64'h706f727461626c65, 48'h0};
         41: text = {48'h737072696e74, 64'h0};
         42: text = {32'h63726f73, 80'h0};
         43: text = {24'h706965, 88'h0};
         44: text = {64'h766f6461666f6e65, 48'h0};
         default: text = '0;
      endcase
      return text;
   endfunction

   function automatic pos_type kw_len(input int k);
      kw_text_type text;
      pos_type     n;
      text = kw_text(k);
      n    = '0;
      for (int p = 0; p < MAX_KEYWORD_LEN; p++) begin
         if (text[(MAX_KEYWORD_LEN-1-p)*8 +: 8] != 8'h00 && int'(n) == p) begin
            n = pos_type'(p + 1);
         end
      end
      return n;
   endfunction

   function automatic char_type kw_char(input int k, input pos_type pos);
      kw_text_type text;
      char_type    c;
      text = kw_text(k);
      c    = '0;
      if (int'(pos) < MAX_KEYWORD_LEN) begin
         c = text[(MAX_KEYWORD_LEN-1-int'(pos))*8 +: 8];
      end
      return c;
   endfunction

endpackage

// ----- rtl/askc_req_if.sv -----
interface askc_req_if
   import askc_pkg::*;
   ();
   logic     valid;
   logic     ready;
   char_type char_byte;
   logic     has_char;
   logic     is_last;

   modport source (output valid, output char_byte, output has_char, output is_last,
                   input ready);
   modport sink   (input valid, input char_byte, input has_char, input is_last,
                   output ready);
endinterface

// ----- rtl/askc_rsp_if.sv -----
interface askc_rsp_if
   import askc_pkg::*;
   ();
   logic      valid;
   logic      ready;
   flags_type agent_flags;

   modport source (output valid, output agent_flags, input ready);
   modport sink   (input valid, input agent_flags, output ready);
endinterface

// ----- rtl/askc_front.sv -----
module askc_front
   import askc_pkg::*;
   (
   askc_req_if.sink  req_chan,
   input  logic      queue_full,
   output logic      push,
   output entry_type push_entry
);

   logic upper;
   logic lower;

   always_comb begin
      upper = (req_chan.char_byte >= 8'h41) && (req_chan.char_byte <= 8'h5a);
      lower = (req_chan.char_byte >= 8'h61) && (req_chan.char_byte <= 8'h7a);

      push_entry.letter    = req_chan.has_char && (upper || lower);
      push_entry.separator = req_chan.has_char && !(upper || lower);
      push_entry.is_last   = req_chan.is_last;
      push_entry.code      = upper ? (req_chan.char_byte + CASE_OFFSET) : req_chan.char_byte;

      req_chan.ready = !queue_full;
      push           = req_chan.valid && !queue_full;
   end

endmodule

// ----- rtl/askc_queue.sv -----
module askc_queue
   import askc_pkg::*;
   (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      full,
   output logic      not_empty,
   output entry_type head
);

   entry_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   always_comb begin
      full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
      not_empty = (count_ff != '0);
      head      = mem_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/askc_back.sv -----
module askc_back
   import askc_pkg::*;
   (
   input  logic      clock,
   input  logic      reset,
   input  logic      not_empty,
   input  entry_type head,
   output logic      pop,
   askc_rsp_if.source rsp_chan
);

   logic        inside_ff, inside_in;
   pos_type     pos_ff, pos_in;
   kw_mask_type alive_ff, alive_in;
   logic        found_ff, found_in;
   logic        rsp_valid_ff, rsp_valid_in;
   flags_type   rsp_flags_ff, rsp_flags_in;

   kw_mask_type base_alive;
   pos_type     base_pos;
   kw_mask_type step_alive;
   kw_mask_type cand_alive;
   pos_type     cand_pos;
   logic        cand_inside;
   kw_mask_type len_mask;
   logic        hit;
   logic        close_tok;
   logic        found_upd;

   always_comb begin
      base_alive = inside_ff ? alive_ff : ALL_ALIVE;
      base_pos   = inside_ff ? pos_ff : '0;

      // compare the letter against every keyword at this position
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
         step_alive[k] = base_alive[k] && (base_pos < kw_len(k))
                         && (kw_char(k, base_pos) == head.code);
      end

      cand_alive  = head.letter ? step_alive : alive_ff;
      cand_inside = head.letter || inside_ff;
      if (head.letter) begin
         cand_pos = (base_pos == POS_MAX) ? base_pos : base_pos + 1'b1;
      end else begin
         cand_pos = pos_ff;
      end

      for (int k = 0; k < NUM_KEYWORDS; k++) begin
         len_mask[k] = (kw_len(k) == cand_pos);
      end

      hit       = cand_inside && |(cand_alive & len_mask);
      close_tok = head.separator || head.is_last;
      found_upd = found_ff || (close_tok && hit);

      pop = not_empty && (!head.is_last || !rsp_valid_ff || rsp_chan.ready);

      inside_in    = inside_ff;
      pos_in       = pos_ff;
      alive_in     = alive_ff;
      found_in     = found_ff;
      rsp_flags_in = rsp_flags_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      if (pop) begin
         if (head.is_last) begin
            inside_in                 = 1'b0;
            pos_in                    = '0;
            alive_in                  = ALL_ALIVE;
            found_in                  = 1'b0;
            rsp_flags_in              = '0;
            rsp_flags_in[FLAG_CHECKED] = 1'b1;
            rsp_flags_in[FLAG_MOBILE]  = found_upd;
            rsp_valid_in              = 1'b1;
         end else begin
            inside_in = cand_inside && !head.separator;
            pos_in    = cand_pos;
            alive_in  = cand_alive;
            found_in  = found_upd;
         end
      end

      rsp_chan.valid       = rsp_valid_ff;
      rsp_chan.agent_flags = rsp_flags_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff    <= 1'b0;
         pos_ff       <= '0;
         alive_ff     <= ALL_ALIVE;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         inside_ff    <= inside_in;
         pos_ff       <= pos_in;
         alive_ff     <= alive_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_flags_ff <= rsp_flags_in;
   end

endmodule

// ----- rtl/agent_string_keyword_classifier.sv -----
// Classifies an agent string fed one byte per transfer on req_chan. Runs of
// ASCII letters form tokens, matched case-insensitively and by whole length
// against a ROM of 45 keywords; every other byte separates tokens. The item
// flagged is_last (with or without a byte) ends the string and yields one
// transfer on rsp_chan: bit 0 always set, bit 1 set when some token matched a
// keyword. A front stage classifies and lower-cases each byte into a
// two-entry queue; the back stage updates the per-token keyword mask and
// position and holds the result in an output register. One item is taken
// every clock while the queue has room, a letter being compared against all
// ROM keywords in parallel; the last item waits in the queue while an earlier
// result is still held on rsp_chan, and then its result is registered.
module agent_string_keyword_classifier
   import askc_pkg::*;
   (
   input  logic       clock,
   input  logic       reset,
   askc_req_if.sink   req_chan,
   askc_rsp_if.source rsp_chan
);

   logic      queue_full;
   logic      queue_not_empty;
   logic      push;
   logic      pop;
   entry_type push_entry;
   entry_type head;

   askc_front u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   askc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head       (head)
   );

   askc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (queue_not_empty),
      .head      (head),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- tb/tb_agent_string_keyword_classifier.sv -----
module tb_agent_string_keyword_classifier;
   import askc_pkg::*;

   localparam int SEND_TARGET   = 450;
   localparam int HOLD_CYCLES   = 80;
   localparam int WATCHDOG_TIME = 2_000_000;
   localparam int MAX_PRINTS    = 40;

   typedef struct {
      string     text;
      char_type  sep;
      bit        end_empty;
      bit        noise;
      bit        typed;
      flags_type flags;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   askc_req_if req_chan ();
   askc_rsp_if rsp_chan ();

   agent_string_keyword_classifier dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   // dictionary, each word stored last letter first
   string kw_backward [NUM_KEYWORDS] = '{
      "diordna", "pdim", "telbat", "dapi", "enohpi", "dopi", "senuti",
      "gnusmas", "eis", "ibom", "koobyalp", "yrrebkcalb", "elibom",
      "tekcirc", "lled", "elibomei", "enohp", "eldnik", "gl", "egl", "tom",
      "enohptrams", "odnetnin", "aikon", "inim", "sonaibmys", "naibmys",
      "sobmys", "naikon", "xaikon", "caikon", "vps", "mlap", "ecruosmlap",
      "somlap", "rerolpxeelibom", "bewsseleriwqer", "nosscireynos",
      "knosscireynos", "psp", "elbatrop", "tnirps", "sorc", "eip",
      "enofadov"
   };

   logic        pr_in_word;
   logic [3:0]  pr_pos;
   kw_mask_type pr_alive;
   logic        pr_found;

   flags_type flags_due [$];
   int        errors        = 0;
   int        results_seen  = 0;
   int        mobile_seen   = 0;
   int        items_sent    = 0;
   int        strings_sent  = 0;
   int        send_idle_pct = 36;
   int        take_idle_pct = 80;
   bit        pressure_on   = 1'b0;

   function automatic bit is_letter(input char_type c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic void clear_prediction();
      pr_in_word = 1'b0;
      pr_pos     = '0;
      pr_alive   = ALL_ALIVE;
      pr_found   = 1'b0;
   endfunction

   function automatic void close_word();
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
         if (pr_alive[k] && kw_backward[k].len() == int'(pr_pos)) begin
            pr_found = 1'b1;
         end
      end
      pr_in_word = 1'b0;
   endfunction

   function automatic void absorb_byte(input char_type c);
      char_type lc;
      int       n;
      if (!is_letter(c)) begin
         if (pr_in_word) begin
            close_word();
         end
         return;
      end
      lc = (c <= "Z") ? c + CASE_OFFSET : c;
      if (!pr_in_word) begin
         pr_in_word = 1'b1;
         pr_pos     = '0;
         pr_alive   = ALL_ALIVE;
      end
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
         n = kw_backward[k].len();
         if (int'(pr_pos) >= n) begin
            pr_alive[k] = 1'b0;
         end else if (char_type'(kw_backward[k][n - 1 - int'(pr_pos)]) != lc) begin
            pr_alive[k] = 1'b0;
         end
      end
      if (int'(pr_pos) < MAX_KEYWORD_LEN + 1) begin
         pr_pos = pr_pos + 4'd1;
      end
   endfunction

   function automatic bit predict_item(input char_type c, input bit has, input bit last,
                                       output flags_type f);
      f = '0;
      if (has) begin
         absorb_byte(c);
      end
      if (!last) begin
         return 1'b0;
      end
      if (pr_in_word) begin
         close_word();
      end
      f[FLAG_CHECKED] = 1'b1;
      f[FLAG_MOBILE]  = pr_found;
      clear_prediction();
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= MAX_PRINTS) begin
         $display("mismatch at %0t: %s", $time, msg);
      end
   endtask

   task automatic check_result(input flags_type got);
      flags_type want;
      results_seen++;
      if (got[FLAG_MOBILE]) begin
         mobile_seen++;
      end
      if (flags_due.size() == 0) begin
         report_mismatch($sformatf("agent_flags %0d with no string pending", got));
         return;
      end
      want = flags_due.pop_front();
      if (got !== want) begin
         report_mismatch($sformatf("agent_flags got %0d want %0d", got, want));
      end
   endtask

   task automatic send_item(input char_type c, input bit has, input bit last,
                            input bit typed, input flags_type typed_flags);
      flags_type f;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.char_byte <= c;
      req_chan.has_char  <= has;
      req_chan.is_last   <= last;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) begin
         @(posedge clock);
      end
      if (predict_item(c, has, last, f)) begin
         flags_due.push_back(typed ? typed_flags : f);
      end
      if (has || last) begin
         items_sent++;
      end
   endtask

   task automatic send_string(input char_type text [$], input bit end_empty, input bit noise,
                              input bit typed, input flags_type typed_flags);
      if (noise && text.size() == 0) begin
         send_item(char_type'($urandom), 1'b0, 1'b0, 1'b0, '0);
      end
      for (int i = 0; i < text.size(); i++) begin
         send_item(text[i], 1'b1, !end_empty && i == text.size() - 1, typed, typed_flags);
         // byte-less filler after the first byte of a string
         if (noise && i == 0) begin
            send_item(char_type'($urandom), 1'b0, 1'b0, 1'b0, '0);
         end
      end
      if (end_empty || text.size() == 0) begin
         send_item(char_type'($urandom), 1'b0, 1'b1, typed, typed_flags);
      end
      strings_sent++;
   endtask

   function automatic char_type random_separator();
      char_type c;
      do begin
         c = char_type'($urandom);
      end while (is_letter(c));
      return c;
   endfunction

   function automatic char_type random_case(input char_type c);
      return $urandom_range(1) ? c - CASE_OFFSET : c;
   endfunction

   task automatic send_random_string();
      char_type text [$];
      char_type word_q [$];
      string    word;
      int       tokens;
      int       len;
      int       pick;
      pick = $urandom_range(99);
      if (pick < 8) begin
         len = $urandom_range(1, 24);
         repeat (len) text.push_back(char_type'($urandom));
      end else begin
         tokens = $urandom_range(0, 5);
         if ($urandom_range(3) == 0) begin
            text.push_back(random_separator());
         end
         for (int t = 0; t < tokens; t++) begin
            if (t > 0) begin
               repeat ($urandom_range(1, 2)) text.push_back(random_separator());
            end
            word_q.delete();
            pick = $urandom_range(99);
            if (pick < 75) begin
               word = kw_backward[$urandom_range(NUM_KEYWORDS - 1)];
               for (int p = word.len() - 1; p >= 0; p--) begin
                  word_q.push_back(char_type'(word[p]));
               end
               // near misses: one letter short or one too many
               if (pick >= 55) begin
                  case ($urandom_range(2))
                     0: word_q.pop_back();
                     1: word_q.push_back(char_type'("a" + $urandom_range(25)));
                     default: word_q.push_front(char_type'("a" + $urandom_range(25)));
                  endcase
               end
            end else begin
               len = $urandom_range(1, 20);
               repeat (len) word_q.push_back(char_type'("a" + $urandom_range(25)));
            end
            foreach (word_q[i]) begin
               text.push_back(random_case(word_q[i]));
            end
         end
         if ($urandom_range(3) == 0) begin
            text.push_back(random_separator());
         end
      end
      send_string(text, 1'($urandom_range(1)), ($urandom_range(19) == 0), 1'b0, '0);
   endtask

   initial begin : receiver
      int stall_left;
      bit pressure_seen;
      stall_left     = 0;
      pressure_seen  = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
               check_result(rsp_chan.agent_flags);
            end
            if (pressure_on && !pressure_seen) begin
               pressure_seen = 1'b1;
               stall_left    = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
               stall_left--;
               rsp_chan.ready <= 1'b0;
            end else begin
               rsp_chan.ready <= ($urandom_range(99) >= take_idle_pct);
            end
         end
      end
   end

   initial begin
      #WATCHDOG_TIME;
      $display("timeout, %0d results still pending", flags_due.size());
      $display("** agent_string_keyword_classifier: FAILED **");
      $finish;
   end

   initial begin
      plan_row_type plan [$];
      char_type     text [$];
      int           target;
      req_chan.valid     = 1'b0;
      req_chan.char_byte = '0;
      req_chan.has_char  = 1'b0;
      req_chan.is_last   = 1'b0;
      clear_prediction();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // text, byte for '#', empty terminator, filler, typed, flags
      plan.push_back('{"", 8'h00, 1'b1, 1'b0, 1'b1, 2'b01});
      plan.push_back('{"", 8'h00, 1'b1, 1'b1, 1'b1, 2'b01});
      plan.push_back('{"mobile", 8'h00, 1'b0, 1'b0, 1'b1, 2'b11});
      plan.push_back('{"MoBiLe", 8'h00, 1'b1, 1'b0, 1'b0, 2'b00});
      plan.push_back('{"xmobile tablets", 8'h00, 1'b0, 1'b0, 1'b1, 2'b01});
      plan.push_back('{"mobileexplorer", 8'h00, 1'b1, 1'b0, 1'b1, 2'b11});
      plan.push_back('{"REQWIRELESSWEBS", 8'h00, 1'b0, 1'b0, 1'b1, 2'b01});
      plan.push_back('{"portableportableportable", 8'h00, 1'b1, 1'b0, 1'b1, 2'b01});
      plan.push_back('{"#mini#", 8'h00, 1'b0, 1'b0, 1'b0, 2'b00});
      plan.push_back('{"@phone[tablet`portable{", 8'h00, 1'b0, 1'b0, 1'b0, 2'b00});
      plan.push_back('{"#Tablet", 8'hff, 1'b1, 1'b1, 1'b0, 2'b00});
      plan.push_back('{"12.34 / zz", 8'h00, 1'b0, 1'b0, 1'b0, 2'b00});
      plan.push_back('{"PHONE", 8'h00, 1'b0, 1'b0, 1'b1, 2'b11});
      plan.push_back('{"min", 8'h00, 1'b1, 1'b0, 1'b1, 2'b01});
      plan.push_back('{"a-b-c MINI", 8'h00, 1'b0, 1'b0, 1'b0, 2'b00});

      foreach (plan[r]) begin
         text.delete();
         for (int i = 0; i < plan[r].text.len(); i++) begin
            if (plan[r].text[i] == "#") begin
               text.push_back(plan[r].sep);
            end else begin
               text.push_back(char_type'(plan[r].text[i]));
            end
         end
         send_string(text, plan[r].end_empty, plan[r].noise, plan[r].typed, plan[r].flags);
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct <= 36;
               take_idle_pct <= 80;
            end
            1: begin
               send_idle_pct <= 80;
               take_idle_pct <= 36;
            end
            default: begin
               send_idle_pct <= 0;
               take_idle_pct <= 0;
               pressure_on   <= 1'b1;
            end
         endcase
         target = items_sent + (SEND_TARGET - items_sent) / (3 - phase);
         while (items_sent < target) begin
            send_random_string();
         end
      end
      req_chan.valid <= 1'b0;

      while (flags_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);

      $display("%0d strings, %0d items, keyword and near-miss tokens, stalls on both sides",
               strings_sent, items_sent);
      $display("%0d results checked, %0d with a keyword token, %0d mismatches",
               results_seen, mobile_seen, errors);
      if (errors == 0) begin
         $display("** agent_string_keyword_classifier: PASSED **");
      end else begin
         $display("** agent_string_keyword_classifier: FAILED **");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/askc_pkg.sv
rtl/askc_req_if.sv
rtl/askc_rsp_if.sv
rtl/askc_front.sv
rtl/askc_queue.sv
rtl/askc_back.sv
rtl/agent_string_keyword_classifier.sv
tb/tb_agent_string_keyword_classifier.sv
